// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Clocked on clk, disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain implication check on the block clock.
`define KST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that starts once the block is out of reset.
`define KST_ASSERT_RUN(lbl, prop, msg) \
	`KST_ASSERT(lbl, prop, msg)

`endif

// ===== src/kst_pkg.sv =====
// Shared types and constants for the keyed sum table.
// No dependencies.
package kst_pkg;

	localparam int KEY_W = 232;  // full key field width on the ports
	localparam int SCORE_W = 32;
	localparam int SEV_W = 8;
	localparam int STS_W = 3;

	localparam logic [STS_W-1:0] STS_UPDATED = 3'd0;
	localparam logic [STS_W-1:0] STS_INSERTED = 3'd1;
	localparam logic [STS_W-1:0] STS_FULL = 3'd2;
	localparam logic [STS_W-1:0] STS_ENTRY = 3'd3;
	localparam logic [STS_W-1:0] STS_EMPTY = 3'd4;

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;

	// per-cycle command broadcast along the row of cells
	typedef struct packed {
		logic cmp;  // compare broadcast key, capture hit
		logic upd;  // hit cell takes its saturated sum
		logic ins;  // shift toward the tail, cell 0 takes the new entry
		logic drn;  // shift toward the head, cell 0 is emitted
	} cell_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CMP   = 4'b0010,
		ST_UPD   = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

endpackage

// ===== src/keyed_sum_table.sv =====
// Top level of the keyed sum table: row of entry cells plus sequencer.
// Depends on kst_pkg and kst_cell.
//
//  channel   handshake            payload
//  --------  -------------------  ---------------------------------------------
//  command   start / busy         func, key_word0..3, severity
//  result    done (1-cycle strobe) status, out_key0..3, total, last
//
// Accumulate: accepting edge captures the normalized key, then busy in the
//   compare and update/insert states; the result strobe comes once back in
//   idle, where a new command can already be taken.
// Drain: busy while emitting one result per stored entry (one when empty),
//   registered back to back from drain; cell 0 is emitted, row shifts to it.
// arst_n clears sequencer, entry count, hit flags and the result strobe;
//   cell keys and scores are only read below the entry count.
// Results cannot be stalled; each beat is valid for exactly one cycle.
module keyed_sum_table import kst_pkg::*; #(
	parameter int TABLE_DEPTH = 32,
	parameter int KEY_BYTES = 29
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      func,
	input  logic [63:0]               key_word0,
	input  logic [63:0]               key_word1,
	input  logic [63:0]               key_word2,
	input  logic [39:0]               key_word3,
	input  logic [SEV_W-1:0]          severity,
	output logic                      done,
	output logic [STS_W-1:0]          status,
	output logic [63:0]               out_key0,
	output logic [63:0]               out_key1,
	output logic [63:0]               out_key2,
	output logic [39:0]               out_key3,
	output logic signed [SCORE_W-1:0] total,
	output logic                      last
);

	localparam int KW = KEY_BYTES * 8;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t                    state_q;
	logic [CW-1:0]             cnt_q;
	logic [KW-1:0]             key_q;      // normalized key of current beat
	logic [SEV_W-1:0]          sev_q;
	logic                      accept;

	// result register
	logic                      done_q;
	logic [STS_W-1:0]          status_q;
	logic [KEY_W-1:0]          okey_q;
	logic signed [SCORE_W-1:0] total_q;
	logic                      last_q;

	// key normalization: a byte survives only if it and every byte ahead of it
	// are nonzero; each byte gets its own AND over a constant prefix mask
	logic [KEY_W-1:0]          raw;
	logic [KEY_BYTES-1:0]      nz;
	logic [KW-1:0]             key_n;

	assign raw = {key_word3, key_word2, key_word1, key_word0};

	for (genvar b = 0; b < KEY_BYTES; b++) begin : g_norm
		localparam logic [KEY_BYTES:0] PFX_FULL = (KEY_BYTES+1)'(1) << (b + 1);
		localparam logic [KEY_BYTES-1:0] PFX = KEY_BYTES'(PFX_FULL - 1'b1);
		assign nz[b] = |raw[8*b +: 8];
		assign key_n[8*b +: 8] = (&(nz | ~PFX)) ? raw[8*b +: 8] : 8'h00;
	end

	// cell row
	cell_ctl_t                 ctl;
	logic [KW-1:0]             cell_key [TABLE_DEPTH];
	logic signed [SCORE_W-1:0] cell_score [TABLE_DEPTH];
	logic signed [SCORE_W-1:0] cell_sum [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]    cell_match;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [KW-1:0]             pk;
		logic signed [SCORE_W-1:0] ps;
		logic [KW-1:0]             nk;
		logic signed [SCORE_W-1:0] ns;

		if (i == 0) begin : g_head
			// new entry enters at the head with its severity as score
			assign pk = key_q;
			assign ps = $signed(SCORE_W'(sev_q));
		end else begin : g_body
			assign pk = cell_key[i-1];
			assign ps = cell_score[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign nk = cell_key[i];
			assign ns = cell_score[i];
		end else begin : g_mid
			assign nk = cell_key[i+1];
			assign ns = cell_score[i+1];
		end

		kst_cell #(
			.KW(KW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.valid      (cnt_q > CW'(i)),
			.key_b      (key_q),
			.sev        (sev_q),
			.prev_key   (pk),
			.prev_score (ps),
			.next_key   (nk),
			.next_score (ns),
			.key        (cell_key[i]),
			.score      (cell_score[i]),
			.match      (cell_match[i]),
			.sum_sat    (cell_sum[i])
		);
	end

	// at most one cell can hit, so an AND-OR picks its saturated sum
	logic                      any_hit;
	logic                      full;
	logic signed [SCORE_W-1:0] hit_sum;

	always_comb begin
		hit_sum = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_sum = hit_sum | (cell_match[i] ? cell_sum[i] : '0);
		end
	end

	assign any_hit = |cell_match;
	assign full    = (cnt_q == CW'(TABLE_DEPTH));
	assign accept  = start && !busy;
	assign busy    = (state_q != ST_IDLE);

	always_comb begin
		ctl.cmp = (state_q == ST_CMP);
		ctl.upd = (state_q == ST_UPD);
		ctl.ins = (state_q == ST_UPD) && !any_hit && !full;
		ctl.drn = (state_q == ST_DRAIN) && (cnt_q != '0);
	end

	// sequencer and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= func ? ST_DRAIN : ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (ctl.ins) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					done_q <= 1'b1;
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end
					// leave after the final entry, or at once when empty
					if (cnt_q == CW'(1) || cnt_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key_n;
			sev_q <= severity;
		end
		if (state_q == ST_UPD) begin
			okey_q <= KEY_W'(key_q);
			last_q <= 1'b1;
			priority if (any_hit) begin
				status_q <= STS_UPDATED;
				total_q  <= hit_sum;
			end else if (full) begin
				status_q <= STS_FULL;
				total_q  <= '0;
			end else begin
				status_q <= STS_INSERTED;
				total_q  <= $signed(SCORE_W'(sev_q));
			end
		end else if (state_q == ST_DRAIN) begin
			if (cnt_q == '0) begin
				status_q <= STS_EMPTY;
				okey_q   <= '0;
				total_q  <= '0;
				last_q   <= 1'b1;
			end else begin
				status_q <= STS_ENTRY;
				okey_q   <= KEY_W'(cell_key[0]);
				total_q  <= cell_score[0];
				last_q   <= (cnt_q == CW'(1));
			end
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign out_key0 = okey_q[63:0];
	assign out_key1 = okey_q[127:64];
	assign out_key2 = okey_q[191:128];
	assign out_key3 = okey_q[231:192];
	assign total    = total_q;
	assign last     = last_q;

endmodule

// ===== src/kst_cell.sv =====
// One entry of the table: key, score, and a compare/add slice.
// Depends on kst_pkg.
module kst_cell import kst_pkg::*; #(
	parameter int KW = 232
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cell_ctl_t                 ctl,
	input  logic                      valid,
	input  logic [KW-1:0]             key_b,
	input  logic [SEV_W-1:0]          sev,
	input  logic [KW-1:0]             prev_key,
	input  logic signed [SCORE_W-1:0] prev_score,
	input  logic [KW-1:0]             next_key,
	input  logic signed [SCORE_W-1:0] next_score,
	output logic [KW-1:0]             key,
	output logic signed [SCORE_W-1:0] score,
	output logic                      match,
	output logic signed [SCORE_W-1:0] sum_sat
);

	logic [KW-1:0]             key_q;
	logic signed [SCORE_W-1:0] score_q;
	logic                      match_q;
	logic signed [SCORE_W:0]   sum;

	assign sum = {score_q[SCORE_W-1], score_q} + $signed({{(SCORE_W+1-SEV_W){1'b0}}, sev});
	assign sum_sat = (sum > $signed({1'b0, SCORE_MAX})) ? SCORE_MAX : sum[SCORE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp) begin
			match_q <= valid && (key_q == key_b);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			key_q   <= prev_key;
			score_q <= prev_score;
		end else if (ctl.drn) begin
			key_q   <= next_key;
			score_q <= next_score;
		end else if (ctl.upd && match_q) begin
			score_q <= sum_sat;
		end
	end

	assign key   = key_q;
	assign score = score_q;
	assign match = match_q;

endmodule

// ===== src/kst_checker.sv =====
// Port-level checks for keyed_sum_table, bound to the top level.
// Depends on kst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kst_checker import kst_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      func,
	input logic                      done,
	input logic [STS_W-1:0]          status,
	input logic signed [SCORE_W-1:0] total,
	input logic                      last
);

	// a taken command always makes the block busy
	`KST_ASSERT(a_busy_after_take, (start && !busy) |=> busy, "busy not raised after command")
	// accumulate answers with a single last beat
	`KST_ASSERT_RUN(a_acc_latency, (start && !busy && !func) |-> ##3 (done && last), "accumulate result late")
	// only drain entry beats may be non-final
	`KST_ASSERT(a_nonlast_entry, (done && !last) |-> (status == STS_ENTRY), "non-final beat not an entry")
	// a fresh entry starts from one severity value
	`KST_ASSERT(a_insert_range, (done && status == STS_INSERTED) |-> (total[31:8] == '0), "insert total out of range")

endmodule

bind keyed_sum_table kst_checker u_kst_checker (.*);
